>>> rtl/clook_disk_request_scheduler_assert.svh
// Assertion macros for the scheduler checker.
`ifndef CLOOK_DISK_REQUEST_SCHEDULER_ASSERT_SVH
`define CLOOK_DISK_REQUEST_SCHEDULER_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define CDRS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the default clock and reset names.
`define CDRS_ASSERT_DEF(lbl, prop, msg) `CDRS_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/cdrs_pkg.sv
// Shared types and constants of the C-LOOK request scheduler.
`default_nettype none
package cdrs_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH   = 16;
  localparam int unsigned DEF_CYLINDER_BITS = 16;
  localparam int unsigned DEF_TAG_BITS      = 8;
  localparam int unsigned COUNT_W           = 5;
  localparam int unsigned STATUS_W          = 2;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_COMMIT
  } ctrl_state_e;

  // Sequencer strobes toward the datapath.
  typedef struct packed {
    logic scan_clear;
    logic rd_en;
    logic commit;
  } ctrl_t;

  // Slot store access strobes.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } mem_cmd_t;

  // What the scan has found so far.
  typedef struct packed {
    logic low_found;
    logic above_found;
    logic free_found;
  } scan_flags_t;

endpackage
`default_nettype wire

>>> rtl/cdrs_slot_store.sv
// Slot memory for cylinder and tag with per-slot valid flip-flops.
`default_nettype none
module cdrs_slot_store #(
  parameter int unsigned QUEUE_DEPTH   = cdrs_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned CYLINDER_BITS = cdrs_pkg::DEF_CYLINDER_BITS,
  parameter int unsigned TAG_BITS      = cdrs_pkg::DEF_TAG_BITS,
  localparam int unsigned IDX_W        = $clog2(QUEUE_DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cdrs_pkg::mem_cmd_t       cmd_i,
  input  logic [IDX_W-1:0]         rd_addr_i,
  input  logic [IDX_W-1:0]         wr_addr_i,
  input  logic [CYLINDER_BITS-1:0] wr_cyl_i,
  input  logic [TAG_BITS-1:0]      wr_tag_i,
  output logic                     rd_ok_o,
  output logic                     rd_slot_valid_o,
  output logic [IDX_W-1:0]         rd_idx_o,
  output logic [CYLINDER_BITS-1:0] rd_cyl_o,
  output logic [TAG_BITS-1:0]      rd_tag_o
);
  import cdrs_pkg::*;

  logic [CYLINDER_BITS-1:0] cyl_mem [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]      tag_mem [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   valid_q;

  logic                     rd_ok_q;
  logic                     rd_valid_q;
  logic [IDX_W-1:0]         rd_idx_q;
  logic [CYLINDER_BITS-1:0] rd_cyl_q;
  logic [TAG_BITS-1:0]      rd_tag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      cyl_mem[wr_addr_i] <= wr_cyl_i;
      tag_mem[wr_addr_i] <= wr_tag_i;
    end
    if (cmd_i.rd_en) begin
      rd_cyl_q <= cyl_mem[rd_addr_i];
      rd_tag_q <= tag_mem[rd_addr_i];
      rd_idx_q <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_ok_q    <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_ok_q <= cmd_i.rd_en;
      if (cmd_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
      if (cmd_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end else if (cmd_i.clr_en) begin
        valid_q[wr_addr_i] <= 1'b0;
      end
    end
  end

  assign rd_ok_o         = rd_ok_q;
  assign rd_slot_valid_o = rd_valid_q;
  assign rd_idx_o        = rd_idx_q;
  assign rd_cyl_o        = rd_cyl_q;
  assign rd_tag_o        = rd_tag_q;

endmodule
`default_nettype wire

>>> rtl/cdrs_scan_unit.sv
// Shared compare unit: tracks lowest, next-above-head and first free slot.
`default_nettype none
module cdrs_scan_unit #(
  parameter int unsigned QUEUE_DEPTH   = cdrs_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned CYLINDER_BITS = cdrs_pkg::DEF_CYLINDER_BITS,
  parameter int unsigned TAG_BITS      = cdrs_pkg::DEF_TAG_BITS,
  localparam int unsigned IDX_W        = $clog2(QUEUE_DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clear_i,
  input  logic                     elem_ok_i,
  input  logic                     elem_valid_i,
  input  logic [IDX_W-1:0]         elem_idx_i,
  input  logic [CYLINDER_BITS-1:0] elem_cyl_i,
  input  logic [TAG_BITS-1:0]      elem_tag_i,
  input  logic                     head_known_i,
  input  logic [CYLINDER_BITS-1:0] head_i,
  output cdrs_pkg::scan_flags_t    flags_o,
  output logic [IDX_W-1:0]         pick_idx_o,
  output logic [CYLINDER_BITS-1:0] pick_cyl_o,
  output logic [TAG_BITS-1:0]      pick_tag_o,
  output logic [IDX_W-1:0]         free_idx_o
);
  import cdrs_pkg::*;

  scan_flags_t              flags_q;
  logic [IDX_W-1:0]         low_idx_q, above_idx_q, free_idx_q;
  logic [CYLINDER_BITS-1:0] low_cyl_q, above_cyl_q;
  logic [TAG_BITS-1:0]      low_tag_q, above_tag_q;
  logic                     take_low, take_above, take_free;

  // Strict less-than keeps the lowest slot on ties, since slots arrive in order.
  always_comb begin
    take_low   = elem_ok_i && elem_valid_i &&
                 (!flags_q.low_found || (elem_cyl_i < low_cyl_q));
    take_above = elem_ok_i && elem_valid_i && head_known_i && (elem_cyl_i > head_i) &&
                 (!flags_q.above_found || (elem_cyl_i < above_cyl_q));
    take_free  = elem_ok_i && !elem_valid_i && !flags_q.free_found;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (clear_i) begin
      flags_q <= '0;
    end else begin
      if (take_low) begin
        flags_q.low_found <= 1'b1;
      end
      if (take_above) begin
        flags_q.above_found <= 1'b1;
      end
      if (take_free) begin
        flags_q.free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_low) begin
      low_idx_q <= elem_idx_i;
      low_cyl_q <= elem_cyl_i;
      low_tag_q <= elem_tag_i;
    end
    if (take_above) begin
      above_idx_q <= elem_idx_i;
      above_cyl_q <= elem_cyl_i;
      above_tag_q <= elem_tag_i;
    end
    if (take_free) begin
      free_idx_q <= elem_idx_i;
    end
  end

  // Wrap to the lowest cylinder when nothing lies above the head.
  always_comb begin
    if (flags_q.above_found) begin
      pick_idx_o = above_idx_q;
      pick_cyl_o = above_cyl_q;
      pick_tag_o = above_tag_q;
    end else begin
      pick_idx_o = low_idx_q;
      pick_cyl_o = low_cyl_q;
      pick_tag_o = low_tag_q;
    end
  end

  assign flags_o    = flags_q;
  assign free_idx_o = free_idx_q;

endmodule
`default_nettype wire

>>> rtl/cdrs_ctrl.sv
// Sequencer: walks the slot address over one scan and strobes the commit.
`default_nettype none
module cdrs_ctrl #(
  parameter int unsigned QUEUE_DEPTH = cdrs_pkg::DEF_QUEUE_DEPTH,
  localparam int unsigned IDX_W      = $clog2(QUEUE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_free_i,
  output logic             in_ready_o,
  output cdrs_pkg::ctrl_t  ctrl_o,
  output logic [IDX_W-1:0] rd_addr_o
);
  import cdrs_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  ctrl_state_e      state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_q == LAST_IDX) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ctrl_o     = '0;
    idx_d      = idx_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o        = 1'b1;
        ctrl_o.scan_clear = in_valid_i;
        idx_d             = '0;
      end
      S_SCAN: begin
        ctrl_o.rd_en = 1'b1;
        idx_d        = idx_q + IDX_W'(1);
      end
      S_LAST: begin
        idx_d = '0;
      end
      S_COMMIT: begin
        // Hold the result until the output register is free.
        ctrl_o.commit = out_free_i;
      end
      default: begin
        idx_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign rd_addr_o = idx_q;

endmodule
`default_nettype wire

>>> rtl/clook_disk_request_scheduler.sv
// C-LOOK disk request scheduler top level: head, count and result register.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------------
//  request  | in        | in_valid_i / in_ready_o | func_i, cylinder_i, request_tag_i
//  result   | out       | out_valid_o / out_ready_i | status_o, served_cylinder_o,
//           |           |                         | served_tag_o, pending_count_o
//
//  Every transaction scans all QUEUE_DEPTH slots through the single read port of the slot
//  memory: the result is loaded after the scan, and a new transaction is taken only once
//  the previous one has committed its result.
//  Reset clears the slot valid flip-flops, head and count at once; no clearing pass.
//  A result waiting in the output register does not block acceptance; only the commit of
//  the following transaction waits for that register to drain.
`default_nettype none
module clook_disk_request_scheduler #(
  parameter int unsigned QUEUE_DEPTH   = cdrs_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned CYLINDER_BITS = cdrs_pkg::DEF_CYLINDER_BITS,
  parameter int unsigned TAG_BITS      = cdrs_pkg::DEF_TAG_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic [CYLINDER_BITS-1:0]     cylinder_i,
  input  logic [TAG_BITS-1:0]          request_tag_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cdrs_pkg::STATUS_W-1:0] status_o,
  output logic [CYLINDER_BITS-1:0]     served_cylinder_o,
  output logic [TAG_BITS-1:0]          served_tag_o,
  output logic [cdrs_pkg::COUNT_W-1:0] pending_count_o
);
  import cdrs_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  ctrl_t                    ctrl;
  mem_cmd_t                 mem_cmd;
  scan_flags_t              flags;
  logic [IDX_W-1:0]         rd_addr, rd_idx, pick_idx, free_idx, wr_addr;
  logic                     rd_ok, rd_slot_valid;
  logic [CYLINDER_BITS-1:0] rd_cyl, pick_cyl;
  logic [TAG_BITS-1:0]      rd_tag, pick_tag;
  logic                     in_fire, out_free;

  logic                     func_q;
  logic [CYLINDER_BITS-1:0] cyl_q;
  logic [TAG_BITS-1:0]      tag_q;

  logic                     head_known_q, head_known_d;
  logic [CYLINDER_BITS-1:0] head_q, head_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;

  logic                     out_valid_q;
  status_e                  status_q, status_d;
  logic [CYLINDER_BITS-1:0] scyl_q, scyl_d;
  logic [TAG_BITS-1:0]      stag_q, stag_d;
  logic [COUNT_W-1:0]       pend_q, pend_d;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  cdrs_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl),
    .rd_addr_o  (rd_addr)
  );

  cdrs_slot_store #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .CYLINDER_BITS(CYLINDER_BITS),
    .TAG_BITS     (TAG_BITS)
  ) u_store (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (mem_cmd),
    .rd_addr_i      (rd_addr),
    .wr_addr_i      (wr_addr),
    .wr_cyl_i       (cyl_q),
    .wr_tag_i       (tag_q),
    .rd_ok_o        (rd_ok),
    .rd_slot_valid_o(rd_slot_valid),
    .rd_idx_o       (rd_idx),
    .rd_cyl_o       (rd_cyl),
    .rd_tag_o       (rd_tag)
  );

  cdrs_scan_unit #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .CYLINDER_BITS(CYLINDER_BITS),
    .TAG_BITS     (TAG_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (ctrl.scan_clear),
    .elem_ok_i   (rd_ok),
    .elem_valid_i(rd_slot_valid),
    .elem_idx_i  (rd_idx),
    .elem_cyl_i  (rd_cyl),
    .elem_tag_i  (rd_tag),
    .head_known_i(head_known_q),
    .head_i      (head_q),
    .flags_o     (flags),
    .pick_idx_o  (pick_idx),
    .pick_cyl_o  (pick_cyl),
    .pick_tag_o  (pick_tag),
    .free_idx_o  (free_idx)
  );

  // Capture the request payload at acceptance.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_i;
      cyl_q  <= cylinder_i;
      tag_q  <= request_tag_i;
    end
  end

  always_comb begin
    mem_cmd       = '0;
    mem_cmd.rd_en = ctrl.rd_en;
    wr_addr       = free_idx;
    status_d      = STAT_OK;
    scyl_d        = '0;
    stag_d        = '0;
    cnt_d         = cnt_q;
    head_d        = head_q;
    head_known_d  = head_known_q;
    if (func_q == FUNC_DEQ) begin
      wr_addr = pick_idx;
      if (flags.low_found) begin
        mem_cmd.clr_en = ctrl.commit;
        scyl_d         = pick_cyl;
        stag_d         = pick_tag;
        cnt_d          = cnt_q - CNT_W'(1);
        head_d         = pick_cyl;
        head_known_d   = 1'b1;
      end else begin
        status_d = STAT_EMPTY;
      end
    end else begin
      if (flags.free_found) begin
        mem_cmd.wr_en = ctrl.commit;
        cnt_d         = cnt_q + CNT_W'(1);
      end else begin
        status_d = STAT_FULL;
      end
    end
    pend_d = COUNT_W'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_known_q <= 1'b0;
      head_q       <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (ctrl.commit) begin
        head_known_q <= head_known_d;
        head_q       <= head_d;
        cnt_q        <= cnt_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      status_q <= status_d;
      scyl_q   <= scyl_d;
      stag_q   <= stag_d;
      pend_q   <= pend_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign served_cylinder_o = scyl_q;
  assign served_tag_o      = stag_q;
  assign pending_count_o   = pend_q;

endmodule
`default_nettype wire

>>> rtl/cdrs_assert_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`default_nettype none
`include "clook_disk_request_scheduler_assert.svh"
module cdrs_assert_checker #(
  parameter int unsigned CYLINDER_BITS = cdrs_pkg::DEF_CYLINDER_BITS,
  parameter int unsigned TAG_BITS      = cdrs_pkg::DEF_TAG_BITS
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [cdrs_pkg::STATUS_W-1:0] status_o,
  input logic [CYLINDER_BITS-1:0]      served_cylinder_o,
  input logic [TAG_BITS-1:0]           served_tag_o,
  input logic [cdrs_pkg::COUNT_W-1:0]  pending_count_o
);
  import cdrs_pkg::*;

  // A scan follows every accepted transaction, so ready drops next cycle.
  property p_busy_after_accept;
    (in_valid_i && in_ready_o) |=> !in_ready_o;
  endproperty

  // Failed transactions carry no served request.
  property p_fail_zero_fields;
    (out_valid_o && (status_o != STAT_OK)) |->
      ((served_cylinder_o == '0) && (served_tag_o == '0));
  endproperty

  property p_empty_count;
    (out_valid_o && (status_o == STAT_EMPTY)) |-> (pending_count_o == '0);
  endproperty

  property p_result_hold;
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(served_cylinder_o) &&
       $stable(served_tag_o) && $stable(pending_count_o));
  endproperty

  `CDRS_ASSERT_DEF(a_busy_after_accept, p_busy_after_accept, "ready stayed high after accept")

  `CDRS_ASSERT_DEF(a_fail_zero_fields, p_fail_zero_fields, "served fields set on failure")

  `CDRS_ASSERT_DEF(a_empty_count, p_empty_count, "empty status with pending requests")

  `CDRS_ASSERT_DEF(a_result_hold, p_result_hold, "stalled result changed")

endmodule

bind clook_disk_request_scheduler cdrs_assert_checker #(
  .CYLINDER_BITS(CYLINDER_BITS),
  .TAG_BITS     (TAG_BITS)
) u_cdrs_assert_checker (.*);
`default_nettype wire
